@@ rtl/rfp_pkg.sv @@
package rfp_pkg;

  // frame constants
  localparam logic [7:0] HDR_BYTE = 8'hA0;
  localparam logic [7:0] MIN_LEN  = 8'd3;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // frame end status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_CMD  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_SUM  = 6'b100000
  } phase_t;

endpackage

@@ rtl/reader_frame_parser_top.sv @@
// registered output: the result of an accepted byte shows at out_* in the cycle after it is taken
// throughput: one byte per cycle; the only stall comes from a held, unread result beat
// the phase register and running sum are updated in the same cycle the byte is taken
// reset (rst_n low, synchronous): parser hunts for a header, sum, count and held bytes
// are cleared, and the result register is empty
module reader_frame_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_frame_address,
  output logic [7:0] out_frame_command,
  output logic [7:0] out_payload_length,
  output logic [1:0] out_status,
  output logic       out_frame_last
);

  rfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;

  logic       res_vld;
  logic       res_kind;
  logic [7:0] res_byte;
  logic [7:0] res_addr;
  logic [7:0] res_cmd;
  logic [7:0] res_len;
  logic [1:0] res_status;

  logic       out_valid_r;
  logic       kind_r;
  logic [7:0] byte_r;
  logic [7:0] faddr_r;
  logic [7:0] fcmd_r;
  logic [7:0] plen_r;
  logic [1:0] status_r;

  logic       accept;
  logic [7:0] b;
  logic [7:0] sum_add;
  logic [7:0] left_dec;

  // input handshake: only a held, stalled result blocks the next byte
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign b        = in_rx_byte;
  assign sum_add  = sum_r + b;
  assign left_dec = left_r - 8'd1;

  // per-byte parse step
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    addr_nxt   = addr_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    res_vld    = 1'b0;
    res_kind   = rfp_pkg::KIND_DATA;
    res_byte   = 8'd0;
    res_addr   = 8'd0;
    res_cmd    = 8'd0;
    res_len    = 8'd0;
    res_status = rfp_pkg::ST_OK;
    case (phase_r)
      rfp_pkg::PH_LEN: begin
        if (b < rfp_pkg::MIN_LEN) begin
          phase_nxt  = rfp_pkg::PH_HUNT;
          sum_nxt    = 8'd0;
          res_vld    = 1'b1;
          res_kind   = rfp_pkg::KIND_END;
          res_status = rfp_pkg::ST_SHORT;
        end else begin
          sum_nxt   = sum_add;
          len_nxt   = b - rfp_pkg::MIN_LEN;
          left_nxt  = b - rfp_pkg::MIN_LEN;
          phase_nxt = rfp_pkg::PH_ADDR;
        end
      end
      rfp_pkg::PH_ADDR: begin
        sum_nxt   = sum_add;
        addr_nxt  = b;
        phase_nxt = rfp_pkg::PH_CMD;
      end
      rfp_pkg::PH_CMD: begin
        sum_nxt   = sum_add;
        cmd_nxt   = b;
        phase_nxt = (left_r != 8'd0) ? rfp_pkg::PH_DATA : rfp_pkg::PH_SUM;
      end
      rfp_pkg::PH_DATA: begin
        sum_nxt  = sum_add;
        left_nxt = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = rfp_pkg::PH_SUM;
        end
        res_vld  = 1'b1;
        res_kind = rfp_pkg::KIND_DATA;
        res_byte = b;
      end
      rfp_pkg::PH_SUM: begin
        phase_nxt  = rfp_pkg::PH_HUNT;
        sum_nxt    = 8'd0;
        res_vld    = 1'b1;
        res_kind   = rfp_pkg::KIND_END;
        res_addr   = addr_r;
        res_cmd    = cmd_r;
        res_len    = len_r;
        res_status = (sum_add == 8'd0) ? rfp_pkg::ST_OK : rfp_pkg::ST_BAD_SUM;
      end
      default: begin
        phase_nxt = rfp_pkg::PH_HUNT;
        if (b == rfp_pkg::HDR_BYTE) begin
          sum_nxt   = rfp_pkg::HDR_BYTE;
          left_nxt  = 8'd0;
          phase_nxt = rfp_pkg::PH_LEN;
        end
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfp_pkg::PH_HUNT;
      left_r  <= 8'd0;
      sum_r   <= 8'd0;
      addr_r  <= 8'd0;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept && res_vld) begin
      kind_r   <= res_kind;
      byte_r   <= res_byte;
      faddr_r  <= res_addr;
      fcmd_r   <= res_cmd;
      plen_r   <= res_len;
      status_r <= res_status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_byte_value     = byte_r;
  assign out_frame_address  = faddr_r;
  assign out_frame_command  = fcmd_r;
  assign out_payload_length = plen_r;
  assign out_status         = status_r;
  assign out_frame_last     = kind_r;

  // payload byte always produces a data beat
  a_data_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == rfp_pkg::PH_DATA |=> out_valid && out_kind == rfp_pkg::KIND_DATA)
    else $error("payload byte did not produce a data beat");

  // checksum byte closes the frame and clears the sum
  a_sum_close: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == rfp_pkg::PH_SUM |=>
      out_valid && out_kind == rfp_pkg::KIND_END && phase_r == rfp_pkg::PH_HUNT && sum_r == 8'd0)
    else $error("checksum byte did not end the frame");

  // error status only on frame end beats
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rfp_pkg::ST_OK |-> out_kind == rfp_pkg::KIND_END)
    else $error("error status on a data beat");

  // hunting never emits a result
  a_hunt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == rfp_pkg::PH_HUNT && !out_valid |=> !out_valid)
    else $error("result emitted while hunting");

  // data phase always has bytes left to count
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rfp_pkg::PH_DATA |-> left_r != 8'd0)
    else $error("data phase with zero bytes left");

endmodule
